/* rtl/psd_pkg.sv */
package psd_pkg;

  localparam int CALIB = 100;

  localparam int AXIS_W = 15;
  localparam int MAG_W = 15;
  localparam int RAD_W = 2 * MAG_W;
  localparam int SUM_W = 25;
  localparam int REM_W = MAG_W + 2;
  localparam int CAND_W = REM_W + 2;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int CIDX_W = $clog2(CALIB + 1);
  localparam int THR_W = 12;
  localparam int GAP_W = 8;
  localparam int STEP_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  // The baseline divide multiplies the sum by a rounded-up reciprocal of CALIB.
  // With the shift below the truncated quotient is exact for every SUM_W-bit sum.
  localparam int MUL_W = SUM_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RECIP_SHIFT = SUM_W + $clog2(CALIB);

  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(MAG_W - 1);
  localparam logic [CIDX_W-1:0] CALIB_COUNT = CIDX_W'(CALIB);
  localparam logic [MUL_W-1:0] CALIB_RECIP =
    MUL_W'(((64'd1 << RECIP_SHIFT) + 64'(CALIB) - 64'd1) / 64'(CALIB));
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

  localparam logic [THR_W-1:0] STEP_THR_RST = THR_W'(350);
  localparam logic [THR_W-1:0] REARM_THR_RST = THR_W'(200);
  localparam logic [GAP_W-1:0] MIN_GAP_RST = GAP_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_THR  = 2'd0,
    REG_REARM_THR = 2'd1,
    REG_MIN_GAP   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] step_thr;
    logic [THR_W-1:0] rearm_thr;
    logic [GAP_W-1:0] min_gap;
  } cfg_regs_t;

  typedef enum logic {
    OP_ROOT = 1'b0,
    OP_DIV  = 1'b1
  } seq_op_t;

  typedef struct packed {
    logic    go;
    seq_op_t op;
  } seq_cmd_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] value;
  } seq_rsp_t;

  function automatic logic [MAG_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
    return v[AXIS_W-1] ? MAG_W'(~v + AXIS_W'(1)) : MAG_W'(v);
  endfunction

endpackage

/* rtl/psd_if.sv */
interface psd_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [psd_pkg::AXIS_W-1:0]   accel_x;
  logic signed [psd_pkg::AXIS_W-1:0]   accel_y;

  modport source (output valid, output accel_x, output accel_y, input ready);
  modport sink (input valid, input accel_x, input accel_y, output ready);
endinterface

interface psd_result_if;
  logic                         valid;
  logic                         ready;
  logic [psd_pkg::STEP_W-1:0]   step_total;
  logic                         step_seen;
  logic                         calibrating;
  logic [psd_pkg::MAG_W-1:0]    magnitude_mg;

  modport source (output valid, output step_total, output step_seen, output calibrating,
                  output magnitude_mg, input ready);
  modport sink (input valid, input step_total, input step_seen, input calibrating,
                input magnitude_mg, output ready);
endinterface

interface psd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [psd_pkg::CFG_IDX_W-1:0]    index;
  logic [psd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/psd_cfg.sv */
module psd_cfg (
  input  logic               clk,
  input  logic               rst,
  psd_cfg_if.sink            cfg,
  output psd_pkg::cfg_regs_t regs
);
  import psd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_thr <= STEP_THR_RST;
      regs.rearm_thr <= REARM_THR_RST;
      regs.min_gap <= MIN_GAP_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STEP_THR:  regs.step_thr <= cfg.data[THR_W-1:0];
        REG_REARM_THR: regs.rearm_thr <= cfg.data[THR_W-1:0];
        REG_MIN_GAP:   regs.min_gap <= cfg.data[GAP_W-1:0];
        default:       ;
      endcase
    end
  end

endmodule

/* rtl/psd_seq.sv */
module psd_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  psd_pkg::seq_cmd_t         cmd,
  input  logic [psd_pkg::MAG_W-1:0] opnd_x,
  input  logic [psd_pkg::MAG_W-1:0] opnd_y,
  input  logic [psd_pkg::SUM_W-1:0] dividend,
  output psd_pkg::seq_rsp_t         rsp
);
  import psd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SQX, S_SQY, S_ROOT, S_DIV} state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [MAG_W-1:0]   opx;
  logic [MAG_W-1:0]   opy;
  logic [RAD_W-1:0]   src;
  logic [REM_W-1:0]   rem;
  logic [MAG_W-1:0]   quo;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  logic [CAND_W-1:0]  cand;
  logic [CAND_W-1:0]  sub;
  logic [CAND_W:0]    diff;
  logic               ge;
  logic [REM_W-1:0]   rem_next;
  logic [MAG_W-1:0]   quo_next;

  // One multiplier forms both squares and the reciprocal product of the baseline divide.
  // One subtractor runs the square root.
  always_comb begin
    if (state == S_DIV) begin
      mul_a = MUL_W'(src[SUM_W-1:0]);
      mul_b = CALIB_RECIP;
    end else if (state == S_SQX) begin
      mul_a = MUL_W'(opx);
      mul_b = MUL_W'(opx);
    end else begin
      mul_a = MUL_W'(opy);
      mul_b = MUL_W'(opy);
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    cand = {rem, src[RAD_W-1 -: 2]};
    sub = CAND_W'({quo, 2'b01});
    diff = {1'b0, cand} - {1'b0, sub};
    ge = ~diff[CAND_W];
    rem_next = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
    quo_next = {quo[MAG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == S_DIV) || ((state == S_ROOT) && (cnt == ROOT_LAST));
      unique case (state)
        S_IDLE: begin
          if (cmd.go) begin
            rem <= '0;
            quo <= '0;
            cnt <= '0;
            if (cmd.op == OP_DIV) begin
              src <= RAD_W'(dividend);
              state <= S_DIV;
            end else begin
              opx <= opnd_x;
              opy <= opnd_y;
              state <= S_SQX;
            end
          end
        end
        S_SQX: begin
          src <= prod[RAD_W-1:0];
          state <= S_SQY;
        end
        S_SQY: begin
          src <= src + prod[RAD_W-1:0];
          state <= S_ROOT;
        end
        S_ROOT: begin
          rem <= rem_next;
          quo <= quo_next;
          src <= src << 2;
          cnt <= cnt + CNT_W'(1);
          if (cnt == ROOT_LAST) begin
            rsp.value <= quo_next;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          rsp.value <= prod[RECIP_SHIFT +: MAG_W];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pedometer_step_detector_top.sv */
// Step detector for a two-axis accelerometer stream.
// The sample channel takes one beat per sample with accel_x and accel_y in milli-g.
// The result channel gives exactly one beat per sample: the step total, whether
// this sample counted a step, whether it went into the baseline, and its magnitude.
// The configuration channel writes register 0 (step threshold), 1 (re-arm
// threshold) or 2 (minimum gap); it is always ready and other indexes are ignored.
// From acceptance to a result in the output register, a sample goes through these
// steps: squaring the axes on the shared multiplier, 15 iterations of the shared
// subtractor for the square root, then handing over the root, updating the detector
// and loading the output register. The sample that closes calibration also passes a
// divide step, in which the shared multiplier divides the baseline sum by
// multiplying it with a reciprocal. The sample channel is ready only while the core
// is idle, so a new sample is not taken until the last one's result is loaded.
// The output register holds a finished result while the next sample is taken;
// if the receiver stalls, the core holds its next result until that beat leaves.
// Reset restores the register defaults, starts a new calibration and clears the
// step total; no result is pending after reset.
module pedometer_step_detector_top (
  input logic          clk,
  input logic          rst,
  psd_sample_if.sink   sample,
  psd_result_if.source result,
  psd_cfg_if.sink      cfg
);
  import psd_pkg::*;

  typedef enum logic [2:0] {T_IDLE, T_ROOT, T_UPDATE, T_DIV, T_EMIT} state_t;

  state_t              state;
  cfg_regs_t           regs;
  seq_cmd_t            cmd;
  seq_rsp_t            rsp;

  logic                in_cal;
  logic [CIDX_W-1:0]   calib_idx;
  logic [SUM_W-1:0]    calib_sum;
  logic [MAG_W-1:0]    baseline;
  logic                armed;
  logic [GAP_W-1:0]    since;
  logic [STEP_W-1:0]   steps;
  logic [MAG_W-1:0]    mag;
  logic                seen;
  logic                cal;
  logic                ovalid;
  logic [STEP_W-1:0]   out_total;
  logic                out_seen;
  logic                out_cal;
  logic [MAG_W-1:0]    out_mag;

  logic                accept;
  logic                div_go;
  logic                emit;
  logic [SUM_W-1:0]    sum_next;
  logic [CIDX_W-1:0]   idx_inc;
  logic [MAG_W-1:0]    dev;
  logic [GAP_W-1:0]    since_inc;
  logic                hit;

  psd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  psd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .opnd_x   (abs_axis(sample.accel_x)),
    .opnd_y   (abs_axis(sample.accel_y)),
    .dividend (sum_next),
    .rsp      (rsp)
  );

  assign sample.ready = (state == T_IDLE);
  assign accept = sample.valid && sample.ready;

  always_comb begin
    sum_next = calib_sum + SUM_W'(mag);
    idx_inc = calib_idx + CIDX_W'(1);
    dev = (mag >= baseline) ? mag - baseline : baseline - mag;
    since_inc = (since == GAP_MAX) ? since : since + GAP_W'(1);
    hit = armed && (dev > MAG_W'(regs.step_thr)) && (since_inc > regs.min_gap);
    div_go = (state == T_UPDATE) && in_cal && (idx_inc == CALIB_COUNT);
    emit = (state == T_EMIT) && (!ovalid || result.ready);
    cmd.go = accept || div_go;
    cmd.op = div_go ? OP_DIV : OP_ROOT;
  end

  assign result.valid = ovalid;
  assign result.step_total = out_total;
  assign result.step_seen = out_seen;
  assign result.calibrating = out_cal;
  assign result.magnitude_mg = out_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      in_cal <= 1'b1;
      calib_idx <= '0;
      calib_sum <= '0;
      baseline <= '0;
      armed <= 1'b1;
      since <= GAP_MAX;
      steps <= '0;
      ovalid <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            state <= T_ROOT;
          end
        end
        T_ROOT: begin
          if (rsp.done) begin
            mag <= rsp.value;
            state <= T_UPDATE;
          end
        end
        T_UPDATE: begin
          cal <= in_cal;
          if (in_cal) begin
            seen <= 1'b0;
            calib_sum <= sum_next;
            if (idx_inc == CALIB_COUNT) begin
              state <= T_DIV;
            end else begin
              calib_idx <= idx_inc;
              state <= T_EMIT;
            end
          end else begin
            seen <= hit;
            if (hit) begin
              armed <= 1'b0;
              since <= '0;
              if (steps != STEP_MAX) begin
                steps <= steps + STEP_W'(1);
              end
            end else begin
              since <= since_inc;
              if (!armed && (dev < MAG_W'(regs.rearm_thr))) begin
                armed <= 1'b1;
              end
            end
            state <= T_EMIT;
          end
        end
        T_DIV: begin
          if (rsp.done) begin
            baseline <= rsp.value;
            in_cal <= 1'b0;
            calib_idx <= '0;
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (emit) begin
            out_total <= steps;
            out_seen <= seen;
            out_cal <= cal;
            out_mag <= mag;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

/* dv/psd_checker.sv */
`timescale 1ns / 100ps

module psd_checker (
  input  logic   clk,
  input  logic   rst,
  psd_sample_if  sample,
  psd_result_if  result,
  psd_cfg_if     cfg,
  output int     mismatches,
  output int     pending_beats
);
  import psd_pkg::*;

  typedef struct packed {
    logic [STEP_W-1:0] total;
    logic              seen;
    logic              cal;
    logic [MAG_W-1:0]  mag;
  } step_report_t;

  step_report_t expected_reports[$];
  step_report_t oldest;

  logic [THR_W-1:0]  step_thr;
  logic [THR_W-1:0]  rearm_thr;
  logic [GAP_W-1:0]  min_gap;

  logic              calibrating_now;
  int                calib_count;
  logic [SUM_W-1:0]  calib_sum;
  logic [MAG_W-1:0]  baseline;
  logic              armed;
  logic [GAP_W-1:0]  since_step;
  logic [STEP_W-1:0] step_count;
  int                err_count = 0;

  function automatic logic [MAG_W-1:0] floor_sqrt(input logic [31:0] n);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root[MAG_W-1:0];
  endfunction

  function automatic int axis_abs(input logic signed [AXIS_W-1:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  function automatic step_report_t detect_step(input logic signed [AXIS_W-1:0] x,
                                               input logic signed [AXIS_W-1:0] y);
    step_report_t     r;
    int               ax;
    int               ay;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] dev;
    ax = axis_abs(x);
    ay = axis_abs(y);
    mag = floor_sqrt(32'(ax * ax + ay * ay));
    r.mag = mag;
    r.seen = 1'b0;
    r.cal = 1'b0;
    if (calibrating_now) begin
      r.cal = 1'b1;
      calib_sum = calib_sum + SUM_W'(mag);
      calib_count++;
      if (calib_count >= CALIB) begin
        baseline = MAG_W'(calib_sum / CALIB);
        calibrating_now = 1'b0;
        calib_count = 0;
      end
    end else begin
      dev = (mag >= baseline) ? mag - baseline : baseline - mag;
      if (since_step != GAP_MAX) since_step++;
      if (armed && dev > step_thr && since_step > min_gap) begin
        armed = 1'b0;
        since_step = '0;
        if (step_count != STEP_MAX) step_count++;
        r.seen = 1'b1;
      end else if (!armed && dev < rearm_thr) begin
        armed = 1'b1;
      end
    end
    r.total = step_count;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      step_thr = STEP_THR_RST;
      rearm_thr = REARM_THR_RST;
      min_gap = MIN_GAP_RST;
      calibrating_now = 1'b1;
      calib_count = 0;
      calib_sum = '0;
      baseline = '0;
      armed = 1'b1;
      since_step = GAP_MAX;
      step_count = '0;
      expected_reports.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_reports.size() == 0) begin
          $error("Result beat arrived with no sample outstanding.");
          err_count++;
        end else begin
          oldest = expected_reports.pop_front();
          compare_field("step_total", 32'(oldest.total), 32'(result.step_total));
          compare_field("step_seen", 32'(oldest.seen), 32'(result.step_seen));
          compare_field("calibrating", 32'(oldest.cal), 32'(result.calibrating));
          compare_field("magnitude_mg", 32'(oldest.mag), 32'(result.magnitude_mg));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_STEP_THR:  step_thr = cfg.data[THR_W-1:0];
          REG_REARM_THR: rearm_thr = cfg.data[THR_W-1:0];
          REG_MIN_GAP:   min_gap = cfg.data[GAP_W-1:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        expected_reports.push_back(detect_step(sample.accel_x, sample.accel_y));
      end
    end
    pending_beats <= expected_reports.size();
    mismatches <= err_count;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import psd_pkg::*;

  localparam int NOMINAL_MG = 1000;
  localparam int STALL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst;

  psd_sample_if sample_ch();
  psd_result_if result_ch();
  psd_cfg_if    cfg_ch();

  int mismatch_count;
  int beats_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int shape_step_thr = 350;
  int cycle_count = 0;
  int hold_left = 0;
  logic stall_armed = 1'b0;
  logic stall_done = 1'b0;

  always #2 clk = ~clk;

  pedometer_step_detector_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  psd_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample_ch),
    .result        (result_ch),
    .cfg           (cfg_ch),
    .mismatches    (mismatch_count),
    .pending_beats (beats_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (stall_armed && !stall_done) begin
      stall_done <= 1'b1;
      hold_left <= STALL_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int rand_axis();
    return int'($urandom_range(32000)) - 16000;
  endfunction

  task automatic send_sample(input int x, input int y);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.accel_x <= AXIS_W'(x);
    sample_ch.accel_y <= AXIS_W'(y);
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic send_mag(input int m);
    int x;
    int y;
    if (m < 0) m = 0;
    if (m > 16000) m = 16000;
    x = int'($urandom_range(2 * m)) - m;
    y = int'($sqrt(real'(m * m - x * x)));
    if ($urandom_range(1)) y = -y;
    if ($urandom_range(1)) send_sample(x, y);
    else send_sample(y, x);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_W'(value);
    if (idx == REG_STEP_THR) shape_step_thr = value % 4096;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_thresholds(input int step, input int rearm, input int gap);
    write_reg(REG_STEP_THR, step);
    write_reg(REG_REARM_THR, rearm);
    write_reg(REG_MIN_GAP, gap);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
  endtask

  // Mostly quiet stretches near the resting magnitude broken by peaks and dips,
  // with some fully random samples mixed in.
  task automatic run_walk(input int n);
    int quiet_left;
    int peak_left;
    int m;
    quiet_left = 0;
    peak_left = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        send_sample(rand_axis(), rand_axis());
      end else begin
        if (quiet_left == 0 && peak_left == 0) begin
          quiet_left = $urandom_range(1, 12);
          peak_left = $urandom_range(1, 3);
        end
        if (quiet_left != 0) begin
          m = NOMINAL_MG + int'($urandom_range(60)) - 30;
          quiet_left--;
        end else if ($urandom_range(99) < 20) begin
          m = NOMINAL_MG - int'($urandom_range(1100));
          peak_left--;
        end else begin
          m = NOMINAL_MG + shape_step_thr + int'($urandom_range(400)) - 60;
          peak_left--;
        end
        send_mag(m);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 79;
    write_reg(REG_UNUSED_IDX, 'hABC);
    set_thresholds(300, 150, 2);
    for (int i = 0; i < CALIB; i++) send_mag(NOMINAL_MG + int'($urandom_range(40)) - 20);

    send_sample(0, 0);
    send_sample(16000, 16000);
    send_sample(-16000, -16000);
    send_sample(16000, -16000);
    send_sample(-16384, -16384);
    send_sample(16383, 16383);
    send_sample(-16384, 16383);
    send_sample(-1, 1);
    send_sample(1000, 0);
    send_sample(0, -1300);
    send_sample(0, -1301);
    send_sample(-1000, 0);
    send_sample(0, 1400);
    send_sample(1000, 0);
    send_sample(-16000, 0);
    send_sample(0, 16000);
    run_walk(380);
    settle();

    send_idle_pct = 79;
    recv_idle_pct = 33;
    set_thresholds(0, 4095, 0);
    run_walk(450);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_thresholds(4095, 0, 254);
    run_walk(150);
    settle();

    set_thresholds(100, 50, 'hFFF);
    run_walk(150);
    settle();

    set_thresholds($urandom_range(200, 800), $urandom_range(50, 190), $urandom_range(20));
    stall_armed <= 1'b1;
    run_walk(550);
    settle();

    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/psd_pkg.sv
rtl/psd_if.sv
rtl/psd_cfg.sv
rtl/psd_seq.sv
rtl/pedometer_step_detector_top.sv
dv/psd_checker.sv
dv/tb.sv
